// ===== rtl/brpc_pkg.sv =====
// Shared types, phase/role/error codes and the type-code table for the
// binary RPC message walker. No dependencies.
package brpc_pkg;

  // Parser phases
  localparam logic [3:0] PH_HWORD    = 4'd0;
  localparam logic [3:0] PH_HNAMELEN = 4'd1;
  localparam logic [3:0] PH_HSKIP    = 4'd2;
  localparam logic [3:0] PH_OLDNAME  = 4'd3;
  localparam logic [3:0] PH_OLDTYPE  = 4'd4;
  localparam logic [3:0] PH_FTYPE    = 4'd5;
  localparam logic [3:0] PH_FID      = 4'd6;
  localparam logic [3:0] PH_ETYPES   = 4'd7;
  localparam logic [3:0] PH_LENSTR   = 4'd8;
  localparam logic [3:0] PH_LENCONT  = 4'd9;
  localparam logic [3:0] PH_PAYLOAD  = 4'd10;
  localparam logic [3:0] PH_DONE     = 4'd11;
  localparam logic [3:0] PH_ERROR    = 4'd12;

  // Frame kinds
  localparam logic [1:0] KIND_STRUCT = 2'd0;
  localparam logic [1:0] KIND_MAP    = 2'd1;
  localparam logic [1:0] KIND_LIST   = 2'd2;

  // Byte roles
  localparam logic [2:0] ROLE_HEADER  = 3'd0;
  localparam logic [2:0] ROLE_FTYPE   = 3'd1;
  localparam logic [2:0] ROLE_FID     = 3'd2;
  localparam logic [2:0] ROLE_ETYPES  = 3'd3;
  localparam logic [2:0] ROLE_LENGTH  = 3'd4;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd5;
  localparam logic [2:0] ROLE_STOP    = 3'd6;
  localparam logic [2:0] ROLE_IGNORED = 3'd7;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_VERSION  = 3'd1;
  localparam logic [2:0] ERR_STRICT   = 3'd2;
  localparam logic [2:0] ERR_UNKNOWN  = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW = 3'd4;

  // Wire type codes
  localparam logic [4:0] TC_STOP    = 5'd0;
  localparam logic [4:0] TC_VOID    = 5'd1;
  localparam logic [4:0] TC_BOOL    = 5'd2;
  localparam logic [4:0] TC_BYTE    = 5'd3;
  localparam logic [4:0] TC_DOUBLE  = 5'd4;
  localparam logic [4:0] TC_I16     = 5'd6;
  localparam logic [4:0] TC_I32     = 5'd8;
  localparam logic [4:0] TC_U64     = 5'd9;
  localparam logic [4:0] TC_I64     = 5'd10;
  localparam logic [4:0] TC_STRING  = 5'd11;
  localparam logic [4:0] TC_STRUCT  = 5'd12;
  localparam logic [4:0] TC_MAP     = 5'd13;
  localparam logic [4:0] TC_SET     = 5'd14;
  localparam logic [4:0] TC_LIST    = 5'd15;
  localparam logic [4:0] TC_UTF8    = 5'd16;
  localparam logic [4:0] TC_UTF16   = 5'd17;
  localparam logic [4:0] TC_UNKNOWN = 5'd31;

  localparam logic [31:0] VER_MASK = 32'hffff_0000;
  localparam logic [31:0] VER_ONE  = 32'h8001_0000;
  localparam logic [31:0] LOW_BYTE = 32'h0000_00ff;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  ktype;
    logic [4:0]  vtype;
    logic [31:0] remain;
    logic        half;
  } frame_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
    logic [4:0] tcode;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] role;
    logic [4:0] depth;
    logic [7:0] message_type;
    logic       last;
    logic [2:0] error;
  } out_beat_t;

  // Decoded start of an element of a given type
  typedef struct packed {
    logic        empty;
    logic        unknown;
    logic        push;
    logic [1:0]  kind;
    logic [3:0]  phase;
    logic        set_cnt;
    logic [31:0] cnt;
    logic        clr_shift;
  } begin_t;

  function automatic logic [4:0] type_code(input logic [7:0] b);
    logic [4:0] t;
    t = TC_UNKNOWN;
    if (b <= 8'd17 && b != 8'd5 && b != 8'd7) t = b[4:0];
    return t;
  endfunction

  function automatic logic zero_size(input logic [4:0] t);
    return (t == TC_STOP) || (t == TC_VOID);
  endfunction

  function automatic begin_t begin_decode(input logic [4:0] t);
    begin_t r;
    r = '0;
    r.phase = PH_PAYLOAD;
    r.set_cnt = 1'b1;
    case (t)
      TC_STOP, TC_VOID: r.empty = 1'b1;
      TC_BOOL, TC_BYTE: r.cnt = 32'd1;
      TC_I16: r.cnt = 32'd2;
      TC_I32: r.cnt = 32'd4;
      TC_DOUBLE, TC_U64, TC_I64: r.cnt = 32'd8;
      TC_STRING, TC_UTF8, TC_UTF16: begin
        r.phase = PH_LENSTR;
        r.cnt = 32'd4;
        r.clr_shift = 1'b1;
      end
      TC_STRUCT: begin
        r.push = 1'b1;
        r.kind = KIND_STRUCT;
        r.phase = PH_FTYPE;
        r.set_cnt = 1'b0;
      end
      TC_MAP: begin
        r.push = 1'b1;
        r.kind = KIND_MAP;
        r.phase = PH_ETYPES;
        r.cnt = 32'd2;
      end
      TC_SET, TC_LIST: begin
        r.push = 1'b1;
        r.kind = KIND_LIST;
        r.phase = PH_ETYPES;
        r.cnt = 32'd1;
      end
      default: r.unknown = 1'b1;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/brpc_fifo.sv =====
// Small register queue used on both sides of the walker.
// No package dependency.
module brpc_fifo #(
  parameter int W = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0] mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (do_pop) rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
  end

endmodule

// ===== rtl/brpc_front.sv =====
// Front end: takes bytes, tags each with its wire type code, queues them.
// Depends on brpc_pkg and brpc_fifo.
module brpc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          in_data_byte,
  input  logic                in_first,
  output logic                beat_valid,
  output brpc_pkg::in_beat_t  beat,
  input  logic                beat_take
);
  brpc_pkg::in_beat_t wbeat;
  logic q_empty;

  always_comb begin
    wbeat.data_byte = in_data_byte;
    wbeat.first     = in_first;
    wbeat.tcode     = brpc_pkg::type_code(in_data_byte);
  end

  brpc_fifo #(.W($bits(brpc_pkg::in_beat_t)), .DEPTH(2)) u_q (
    .clk(clk), .rst_n(rst_n),
    .push(push), .wdata(wbeat), .full(full),
    .pop(beat_take), .rdata(beat), .empty(q_empty)
  );

  assign beat_valid = !q_empty;

endmodule

// ===== rtl/brpc_back.sv =====
// Back end: header/body walker with the nesting stack; unwinds one frame
// per cycle after an element completes, unless res_full. Depends on brpc_pkg.
module brpc_back #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                strict,
  input  logic                beat_valid,
  input  brpc_pkg::in_beat_t  beat,
  output logic                beat_take,
  input  logic                res_full,
  output logic                res_push,
  output brpc_pkg::out_beat_t res
);
  localparam int IW = $clog2(STACK_DEPTH);
  localparam int LW = $clog2(STACK_DEPTH + 1);

  brpc_pkg::frame_t stk_r [STACK_DEPTH];

  logic [3:0]  phase_r, phase_nxt;
  logic [LW-1:0] level_r, level_nxt;
  logic [31:0] cnt_r, cnt_nxt, shift_r, shift_nxt;
  logic [4:0]  ctype_r, ctype_nxt;
  logic [7:0]  mtype_r, mtype_nxt;
  logic [2:0]  err_r, err_nxt;
  logic        resume_r, resume_nxt;
  logic [2:0]  prole_r, prole_nxt;

  logic [IW-1:0] top_idx, push_idx;
  brpc_pkg::frame_t top, top_wd, push_wd;
  logic top_we, push_we;
  logic [4:0] beg_type;
  brpc_pkg::begin_t bg;
  logic do_begin;

  logic [3:0]  e_phase;
  logic [31:0] e_cnt, e_shift, cnt_dec, shift_in, n4;
  logic [2:0]  role;
  logic        last;

  assign top_idx = (level_r == '0) ? IW'(STACK_DEPTH - 1) : IW'(level_r - 1'b1);
  assign top = stk_r[top_idx];

  // Element type fed to the shared begin decoder
  always_comb begin
    beg_type = ctype_r;
    if (resume_r) begin
      beg_type = (top.kind == brpc_pkg::KIND_MAP && top.half) ? top.vtype : top.ktype;
    end
  end
  assign bg = brpc_pkg::begin_decode(beg_type);

  always_comb begin
    e_phase  = beat.first ? brpc_pkg::PH_HWORD : phase_r;
    e_cnt    = beat.first ? 32'd4 : cnt_r;
    e_shift  = beat.first ? 32'd0 : shift_r;
    cnt_dec  = e_cnt - 32'd1;
    shift_in = {e_shift[23:0], beat.data_byte};
    n4       = shift_in + 32'd4;

    phase_nxt = phase_r;
    level_nxt = level_r;
    cnt_nxt = cnt_r;
    shift_nxt = shift_r;
    ctype_nxt = ctype_r;
    mtype_nxt = mtype_r;
    err_nxt = err_r;
    resume_nxt = resume_r;
    prole_nxt = prole_r;
    top_we = 1'b0;
    top_wd = top;
    push_we = 1'b0;
    push_idx = '0;
    push_wd = '0;
    do_begin = 1'b0;
    role = brpc_pkg::ROLE_IGNORED;
    last = 1'b0;
    beat_take = 1'b0;
    res_push = 1'b0;

    if (!res_full && resume_r) begin
      // one unwind step
      role = prole_r;
      if (level_r == '0) begin
        phase_nxt = brpc_pkg::PH_DONE;
        last = 1'b1;
        resume_nxt = 1'b0;
      end else begin
        case (top.kind)
          brpc_pkg::KIND_STRUCT: begin
            phase_nxt = brpc_pkg::PH_FTYPE;
            resume_nxt = 1'b0;
          end
          brpc_pkg::KIND_LIST: begin
            if (top.remain == '0) begin
              level_nxt = level_r - 1'b1;
            end else begin
              top_we = 1'b1;
              top_wd.remain = top.remain - 32'd1;
              do_begin = 1'b1;
              if (bg.empty) top_wd.remain = '0;
              else resume_nxt = 1'b0;
            end
          end
          default: begin
            if (!top.half) begin
              if (top.remain == '0) begin
                level_nxt = level_r - 1'b1;
              end else begin
                top_we = 1'b1;
                top_wd.remain = top.remain - 32'd1;
                top_wd.half = 1'b1;
                do_begin = 1'b1;
                if (!bg.empty) resume_nxt = 1'b0;
              end
            end else begin
              top_we = 1'b1;
              top_wd.half = 1'b0;
              do_begin = 1'b1;
              if (!bg.empty) resume_nxt = 1'b0;
            end
          end
        endcase
      end
    end else if (!res_full && beat_valid) begin
      beat_take = 1'b1;
      if (beat.first) begin
        level_nxt = '0;
        cnt_nxt = 32'd4;
        shift_nxt = '0;
        ctype_nxt = '0;
        mtype_nxt = '0;
        err_nxt = brpc_pkg::ERR_NONE;
        phase_nxt = brpc_pkg::PH_HWORD;
      end
      case (e_phase)
        brpc_pkg::PH_HWORD: begin
          role = brpc_pkg::ROLE_HEADER;
          shift_nxt = shift_in;
          cnt_nxt = cnt_dec;
          if (cnt_dec == '0) begin
            if (shift_in[31]) begin
              if ((shift_in & brpc_pkg::VER_MASK) != brpc_pkg::VER_ONE) begin
                phase_nxt = brpc_pkg::PH_ERROR;
                err_nxt = brpc_pkg::ERR_VERSION;
              end else begin
                mtype_nxt = 8'(shift_in & brpc_pkg::LOW_BYTE);
                phase_nxt = brpc_pkg::PH_HNAMELEN;
                cnt_nxt = 32'd4;
                shift_nxt = '0;
              end
            end else if (strict) begin
              phase_nxt = brpc_pkg::PH_ERROR;
              err_nxt = brpc_pkg::ERR_STRICT;
            end else if (shift_in == '0) begin
              phase_nxt = brpc_pkg::PH_OLDTYPE;
            end else begin
              phase_nxt = brpc_pkg::PH_OLDNAME;
              cnt_nxt = shift_in;
            end
          end
        end
        brpc_pkg::PH_HNAMELEN: begin
          role = brpc_pkg::ROLE_HEADER;
          shift_nxt = shift_in;
          cnt_nxt = cnt_dec;
          if (cnt_dec == '0) begin
            if (n4 == '0) begin
              level_nxt = LW'(1);
              push_we = 1'b1;
              push_wd.kind = brpc_pkg::KIND_STRUCT;
              phase_nxt = brpc_pkg::PH_FTYPE;
            end else begin
              phase_nxt = brpc_pkg::PH_HSKIP;
              cnt_nxt = n4;
            end
          end
        end
        brpc_pkg::PH_HSKIP: begin
          role = brpc_pkg::ROLE_HEADER;
          cnt_nxt = cnt_dec;
          if (cnt_dec == '0) begin
            level_nxt = LW'(1);
            push_we = 1'b1;
            push_wd.kind = brpc_pkg::KIND_STRUCT;
            phase_nxt = brpc_pkg::PH_FTYPE;
          end
        end
        brpc_pkg::PH_OLDNAME: begin
          role = brpc_pkg::ROLE_HEADER;
          cnt_nxt = cnt_dec;
          if (cnt_dec == '0) phase_nxt = brpc_pkg::PH_OLDTYPE;
        end
        brpc_pkg::PH_OLDTYPE: begin
          role = brpc_pkg::ROLE_HEADER;
          mtype_nxt = beat.data_byte;
          phase_nxt = brpc_pkg::PH_HSKIP;
          cnt_nxt = 32'd4;
        end
        brpc_pkg::PH_FTYPE: begin
          if (beat.tcode == brpc_pkg::TC_STOP) begin
            role = brpc_pkg::ROLE_STOP;
            if (level_r != '0) level_nxt = level_r - 1'b1;
            resume_nxt = 1'b1;
          end else begin
            role = brpc_pkg::ROLE_FTYPE;
            ctype_nxt = beat.tcode;
            phase_nxt = brpc_pkg::PH_FID;
            cnt_nxt = 32'd2;
          end
        end
        brpc_pkg::PH_FID: begin
          role = brpc_pkg::ROLE_FID;
          cnt_nxt = cnt_dec;
          if (cnt_dec == '0) begin
            do_begin = 1'b1;
            if (bg.empty) resume_nxt = 1'b1;
          end
        end
        brpc_pkg::PH_ETYPES: begin
          role = brpc_pkg::ROLE_ETYPES;
          top_we = 1'b1;
          if (top.kind == brpc_pkg::KIND_MAP && e_cnt == 32'd2) top_wd.ktype = beat.tcode;
          else if (top.kind == brpc_pkg::KIND_MAP) top_wd.vtype = beat.tcode;
          else top_wd.ktype = beat.tcode;
          cnt_nxt = cnt_dec;
          if (cnt_dec == '0) begin
            phase_nxt = brpc_pkg::PH_LENCONT;
            cnt_nxt = 32'd4;
            shift_nxt = '0;
          end
        end
        brpc_pkg::PH_LENCONT: begin
          role = brpc_pkg::ROLE_LENGTH;
          shift_nxt = shift_in;
          cnt_nxt = cnt_dec;
          if (cnt_dec == '0) begin
            top_we = 1'b1;
            top_wd.remain = shift_in;
            top_wd.half = 1'b0;
            if (top.kind == brpc_pkg::KIND_MAP && brpc_pkg::zero_size(top.ktype) &&
                brpc_pkg::zero_size(top.vtype)) top_wd.remain = '0;
            resume_nxt = 1'b1;
          end
        end
        brpc_pkg::PH_LENSTR: begin
          role = brpc_pkg::ROLE_LENGTH;
          shift_nxt = shift_in;
          cnt_nxt = cnt_dec;
          if (cnt_dec == '0) begin
            if (shift_in == '0) begin
              resume_nxt = 1'b1;
            end else begin
              phase_nxt = brpc_pkg::PH_PAYLOAD;
              cnt_nxt = shift_in;
            end
          end
        end
        brpc_pkg::PH_PAYLOAD: begin
          role = brpc_pkg::ROLE_PAYLOAD;
          cnt_nxt = cnt_dec;
          if (cnt_dec == '0) resume_nxt = 1'b1;
        end
        default: role = brpc_pkg::ROLE_IGNORED;
      endcase
      prole_nxt = role;
    end

    // Start of a new element (shared by field path and unwind path)
    if (do_begin && !bg.empty) begin
      if (bg.unknown) begin
        phase_nxt = brpc_pkg::PH_ERROR;
        err_nxt = brpc_pkg::ERR_UNKNOWN;
      end else if (bg.push) begin
        if (level_nxt >= LW'(STACK_DEPTH)) begin
          phase_nxt = brpc_pkg::PH_ERROR;
          err_nxt = brpc_pkg::ERR_OVERFLOW;
        end else begin
          push_we = 1'b1;
          push_idx = IW'(level_nxt);
          push_wd.kind = bg.kind;
          level_nxt = level_nxt + 1'b1;
          phase_nxt = bg.phase;
          if (bg.set_cnt) cnt_nxt = bg.cnt;
        end
      end else begin
        phase_nxt = bg.phase;
        cnt_nxt = bg.cnt;
        if (bg.clr_shift) shift_nxt = '0;
      end
    end

    res_push = (beat_take || resume_r) && !res_full && !resume_nxt;
    res.role = role;
    res.depth = 5'(level_nxt);
    res.message_type = mtype_nxt;
    res.last = last;
    res.error = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= brpc_pkg::PH_HWORD;
      level_r <= '0;
      cnt_r <= 32'd4;
      shift_r <= '0;
      ctype_r <= '0;
      mtype_r <= '0;
      err_r <= brpc_pkg::ERR_NONE;
      resume_r <= 1'b0;
      prole_r <= brpc_pkg::ROLE_HEADER;
    end else begin
      phase_r <= phase_nxt;
      level_r <= level_nxt;
      cnt_r <= cnt_nxt;
      shift_r <= shift_nxt;
      ctype_r <= ctype_nxt;
      mtype_r <= mtype_nxt;
      err_r <= err_nxt;
      resume_r <= resume_nxt;
      prole_r <= prole_nxt;
    end
  end

  // Frame stack: no reset, every frame is pushed before it is read
  always_ff @(posedge clk) begin
    if (top_we) stk_r[top_idx] <= top_wd;
    if (push_we) stk_r[push_idx] <= push_wd;
  end

endmodule

// ===== rtl/binary_rpc_message_walker_core.sv =====
// Path: a pushed byte is registered in the input queue, walked by the back end
//   combinationally, its beat registered in the result queue after any unwind steps.
// Throughput: one byte per cycle while the result queue has room; a byte ending an
//   element adds an unwind step, plus one per frame popped or zero-size element skipped.
// Reset (synchronous, rst_n low): queues emptied, walker back to header
//   start, strict mode cleared; the frame stack keeps its contents.
module binary_rpc_message_walker_core #(
  parameter int STACK_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  // input queue side
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_data_byte,
  input  logic       in_first,
  // result queue side
  output logic       empty,
  input  logic       pop,
  output logic [2:0] out_role,
  output logic [4:0] out_depth,
  output logic [7:0] out_message_type,
  output logic       out_last,
  output logic [2:0] out_error,
  // config
  input  logic       cfg_wr_en,
  input  logic       cfg_strict
);
  logic cfg_strict_r;

  logic               beat_valid, beat_take;
  brpc_pkg::in_beat_t beat;
  logic               res_full, res_push;
  brpc_pkg::out_beat_t res, res_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_strict_r <= 1'b0;
    end else if (cfg_wr_en) begin
      cfg_strict_r <= cfg_strict;
    end
  end

  // Front: classify each byte's type code and queue it
  brpc_front u_front (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full),
    .in_data_byte(in_data_byte), .in_first(in_first),
    .beat_valid(beat_valid), .beat(beat), .beat_take(beat_take)
  );

  // Back: header/body walker with nesting stack
  brpc_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n),
    .strict(cfg_strict_r),
    .beat_valid(beat_valid), .beat(beat), .beat_take(beat_take),
    .res_full(res_full), .res_push(res_push), .res(res)
  );

  // Result queue decouples the walker from the consumer
  brpc_fifo #(.W($bits(brpc_pkg::out_beat_t)), .DEPTH(2)) u_res_q (
    .clk(clk), .rst_n(rst_n),
    .push(res_push), .wdata(res), .full(res_full),
    .pop(pop), .rdata(res_q), .empty(empty)
  );

  assign out_role         = res_q.role;
  assign out_depth        = res_q.depth;
  assign out_message_type = res_q.message_type;
  assign out_last         = res_q.last;
  assign out_error        = res_q.error;

endmodule

// ===== rtl/brpc_checks.sv =====
// Port-level checks for the walker top level, attached by bind.
// Depends on brpc_pkg.
module brpc_checks (
  input logic       clk,
  input logic       rst_n,
  input logic       empty,
  input logic       pop,
  input logic [2:0] out_role,
  input logic [4:0] out_depth,
  input logic       out_last,
  input logic [2:0] out_error
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_role) && $stable(out_depth)))
    else $error("waiting result beat changed");

  a_last_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_last) |-> (out_depth == 5'd0 && out_error == brpc_pkg::ERR_NONE))
    else $error("last beat with open depth or error");

  a_last_role: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_last) |-> (out_role == brpc_pkg::ROLE_STOP ||
      out_role == brpc_pkg::ROLE_FID || out_role == brpc_pkg::ROLE_LENGTH ||
      out_role == brpc_pkg::ROLE_PAYLOAD))
    else $error("last beat on a byte that cannot end an element");

endmodule

bind binary_rpc_message_walker_core brpc_checks u_brpc_checks (
  .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop),
  .out_role(out_role), .out_depth(out_depth),
  .out_last(out_last), .out_error(out_error)
);

// ===== test/tb_top.sv =====
// Self-checking bench for binary_rpc_message_walker_core: a byte-level walker
// model predicts one beat per byte. Depends on rtl/brpc_pkg.sv and the core.
module tb_top;

  localparam int DEPTH = 16;

  // ---------------------------------------------------------------- clock/reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- DUT ports
  logic       push = 1'b0, pop = 1'b0, full, empty;
  logic [7:0] in_data_byte = '0;
  logic       in_first = 1'b0;
  logic [2:0] out_role, out_error;
  logic [4:0] out_depth;
  logic [7:0] out_message_type;
  logic       out_last;
  logic       cfg_wr_en = 1'b0, cfg_strict = 1'b0;

  binary_rpc_message_walker_core #(.STACK_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_data_byte(in_data_byte), .in_first(in_first),
    .empty(empty), .pop(pop), .out_role(out_role), .out_depth(out_depth),
    .out_message_type(out_message_type), .out_last(out_last), .out_error(out_error),
    .cfg_wr_en(cfg_wr_en), .cfg_strict(cfg_strict)
  );

  // ---------------------------------------------------------------- byte queues
  typedef struct {
    logic [7:0]          b;
    logic                first;
    bit                  typed;    // want holds a hand-written expectation
    brpc_pkg::out_beat_t want;
  } byte_item_t;

  byte_item_t           byte_q[$];     // bytes waiting to be offered
  brpc_pkg::out_beat_t  beat_q[$];     // predicted beats, oldest first
  logic [7:0]           wire_q[$];     // scratch for the message builder
  int          errs = 0;
  int          idle_pct = 0, stall_pct = 0;
  bit          hold_req = 1'b0;

  // ---------------------------------------------------------------- walker model
  typedef enum int {ELEM_BEGUN, ELEM_EMPTY, ELEM_FAILED} elem_res_t;

  logic [1:0]  fr_kind [DEPTH];
  logic [4:0]  fr_ktype[DEPTH];
  logic [4:0]  fr_vtype[DEPTH];
  logic [31:0] fr_left [DEPTH];
  logic        fr_half [DEPTH];
  int unsigned lvl;
  logic [3:0]  phase;
  logic [31:0] cnt, acc;
  logic [4:0]  cur_type;
  logic [7:0]  msg_type;
  logic [2:0]  err_code;
  logic        strict_mode;

  function automatic void walker_clear();
    for (int i = 0; i < DEPTH; i++) begin
      fr_kind[i] = brpc_pkg::KIND_STRUCT; fr_ktype[i] = '0; fr_vtype[i] = '0;
      fr_left[i] = '0; fr_half[i] = 1'b0;
    end
    lvl = 0; phase = brpc_pkg::PH_HWORD; cnt = 4; acc = '0;
    cur_type = '0; msg_type = '0; err_code = brpc_pkg::ERR_NONE;
  endfunction

  function automatic void walker_fail(logic [2:0] code);
    err_code = code;
    phase = brpc_pkg::PH_ERROR;
  endfunction

  function automatic bit frame_push(logic [1:0] kind);
    if (lvl >= DEPTH) begin
      walker_fail(brpc_pkg::ERR_OVERFLOW);
      return 1'b0;
    end
    fr_kind[lvl] = kind; fr_ktype[lvl] = '0; fr_vtype[lvl] = '0;
    fr_left[lvl] = '0; fr_half[lvl] = 1'b0;
    lvl++;
    return 1'b1;
  endfunction

  function automatic void to_payload(logic [31:0] n);
    phase = brpc_pkg::PH_PAYLOAD;
    cnt = n;
  endfunction

  function automatic elem_res_t start_elem(logic [4:0] t);
    case (t)
      brpc_pkg::TC_STOP, brpc_pkg::TC_VOID: return ELEM_EMPTY;
      brpc_pkg::TC_BOOL, brpc_pkg::TC_BYTE: to_payload(1);
      brpc_pkg::TC_I16: to_payload(2);
      brpc_pkg::TC_I32: to_payload(4);
      brpc_pkg::TC_DOUBLE, brpc_pkg::TC_U64, brpc_pkg::TC_I64: to_payload(8);
      brpc_pkg::TC_STRING, brpc_pkg::TC_UTF8, brpc_pkg::TC_UTF16: begin
        phase = brpc_pkg::PH_LENSTR; cnt = 4; acc = '0;
      end
      brpc_pkg::TC_STRUCT: begin
        if (!frame_push(brpc_pkg::KIND_STRUCT)) return ELEM_FAILED;
        phase = brpc_pkg::PH_FTYPE;
      end
      brpc_pkg::TC_MAP: begin
        if (!frame_push(brpc_pkg::KIND_MAP)) return ELEM_FAILED;
        phase = brpc_pkg::PH_ETYPES; cnt = 2;
      end
      brpc_pkg::TC_SET, brpc_pkg::TC_LIST: begin
        if (!frame_push(brpc_pkg::KIND_LIST)) return ELEM_FAILED;
        phase = brpc_pkg::PH_ETYPES; cnt = 1;
      end
      default: begin
        walker_fail(brpc_pkg::ERR_UNKNOWN);
        return ELEM_FAILED;
      end
    endcase
    return ELEM_BEGUN;
  endfunction

  // Element done in the top frame: pop finished frames, start the next element.
  // Returns 1 when the outermost struct closes.
  function automatic bit unwind();
    int        i;
    elem_res_t r;
    while (1) begin
      if (lvl == 0) begin
        phase = brpc_pkg::PH_DONE;
        return 1'b1;
      end
      i = (lvl - 1) % DEPTH;
      if (fr_kind[i] == brpc_pkg::KIND_STRUCT) begin
        phase = brpc_pkg::PH_FTYPE;
        return 1'b0;
      end
      if (fr_kind[i] == brpc_pkg::KIND_LIST) begin
        if (fr_left[i] == 0) begin
          lvl--;
          continue;
        end
        fr_left[i]--;
        r = start_elem(fr_ktype[i]);
        if (r == ELEM_EMPTY) begin
          fr_left[i] = '0;
          continue;
        end
        return 1'b0;
      end
      // map: key half then value half
      if (!fr_half[i]) begin
        if (fr_left[i] == 0) begin
          lvl--;
          continue;
        end
        fr_left[i]--;
        fr_half[i] = 1'b1;
        r = start_elem(fr_ktype[i]);
      end else begin
        fr_half[i] = 1'b0;
        r = start_elem(fr_vtype[i]);
      end
      if (r != ELEM_EMPTY) return 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic void open_body();
    lvl = 0;
    void'(frame_push(brpc_pkg::KIND_STRUCT));
    phase = brpc_pkg::PH_FTYPE;
  endfunction

  function automatic brpc_pkg::out_beat_t walk_byte(logic [7:0] b, logic first);
    brpc_pkg::out_beat_t o;
    logic [2:0]  role;
    bit          done;
    int          top;
    logic [4:0]  t;
    logic [31:0] w;
    role = brpc_pkg::ROLE_IGNORED;
    done = 1'b0;
    top = (lvl + DEPTH - 1) % DEPTH;   // taken before a restart, as in hardware
    t = (b <= 8'd17 && b != 8'd5 && b != 8'd7) ? b[4:0] : brpc_pkg::TC_UNKNOWN;
    if (first) walker_clear();
    case (phase)
      brpc_pkg::PH_HWORD: begin
        role = brpc_pkg::ROLE_HEADER;
        acc = (acc << 8) | b;
        cnt--;
        if (cnt == 0) begin
          w = acc;
          if (w[31]) begin
            if ((w & brpc_pkg::VER_MASK) != brpc_pkg::VER_ONE)
              walker_fail(brpc_pkg::ERR_VERSION);
            else begin
              msg_type = w[7:0];
              phase = brpc_pkg::PH_HNAMELEN; cnt = 4; acc = '0;
            end
          end else if (strict_mode) walker_fail(brpc_pkg::ERR_STRICT);
          else if (w == 0) phase = brpc_pkg::PH_OLDTYPE;
          else begin
            phase = brpc_pkg::PH_OLDNAME; cnt = w;
          end
        end
      end
      brpc_pkg::PH_HNAMELEN: begin
        role = brpc_pkg::ROLE_HEADER;
        acc = (acc << 8) | b;
        cnt--;
        if (cnt == 0) begin
          w = acc + 32'd4;
          if (w == 0) open_body();
          else begin
            phase = brpc_pkg::PH_HSKIP; cnt = w;
          end
        end
      end
      brpc_pkg::PH_HSKIP: begin
        role = brpc_pkg::ROLE_HEADER;
        cnt--;
        if (cnt == 0) open_body();
      end
      brpc_pkg::PH_OLDNAME: begin
        role = brpc_pkg::ROLE_HEADER;
        cnt--;
        if (cnt == 0) phase = brpc_pkg::PH_OLDTYPE;
      end
      brpc_pkg::PH_OLDTYPE: begin
        role = brpc_pkg::ROLE_HEADER;
        msg_type = b;
        phase = brpc_pkg::PH_HSKIP; cnt = 4;
      end
      brpc_pkg::PH_FTYPE: begin
        if (t == brpc_pkg::TC_STOP) begin
          role = brpc_pkg::ROLE_STOP;
          if (lvl > 0) lvl--;
          done = unwind();
        end else begin
          role = brpc_pkg::ROLE_FTYPE;
          cur_type = t;
          phase = brpc_pkg::PH_FID; cnt = 2;
        end
      end
      brpc_pkg::PH_FID: begin
        role = brpc_pkg::ROLE_FID;
        cnt--;
        if (cnt == 0 && start_elem(cur_type) == ELEM_EMPTY) done = unwind();
      end
      brpc_pkg::PH_ETYPES: begin
        role = brpc_pkg::ROLE_ETYPES;
        if (fr_kind[top] == brpc_pkg::KIND_MAP && cnt == 2) fr_ktype[top] = t;
        else if (fr_kind[top] == brpc_pkg::KIND_MAP) fr_vtype[top] = t;
        else fr_ktype[top] = t;
        cnt--;
        if (cnt == 0) begin
          phase = brpc_pkg::PH_LENCONT; cnt = 4; acc = '0;
        end
      end
      brpc_pkg::PH_LENCONT: begin
        role = brpc_pkg::ROLE_LENGTH;
        acc = (acc << 8) | b;
        cnt--;
        if (cnt == 0) begin
          fr_left[top] = acc;
          fr_half[top] = 1'b0;
          // map of two zero-size halves: nothing to walk
          if (fr_kind[top] == brpc_pkg::KIND_MAP && fr_ktype[top] <= brpc_pkg::TC_VOID &&
              fr_vtype[top] <= brpc_pkg::TC_VOID) fr_left[top] = '0;
          done = unwind();
        end
      end
      brpc_pkg::PH_LENSTR: begin
        role = brpc_pkg::ROLE_LENGTH;
        acc = (acc << 8) | b;
        cnt--;
        if (cnt == 0) begin
          if (acc == 0) done = unwind();
          else to_payload(acc);
        end
      end
      brpc_pkg::PH_PAYLOAD: begin
        role = brpc_pkg::ROLE_PAYLOAD;
        cnt--;
        if (cnt == 0) done = unwind();
      end
      default: role = brpc_pkg::ROLE_IGNORED;
    endcase
    o.role = role;
    o.depth = lvl[4:0];
    o.message_type = msg_type;
    o.last = done;
    o.error = err_code;
    return o;
  endfunction

  // ---------------------------------------------------------------- message builder
  localparam logic [4:0] FIELD_TYPES[15] = '{brpc_pkg::TC_VOID, brpc_pkg::TC_BOOL,
    brpc_pkg::TC_BYTE, brpc_pkg::TC_DOUBLE, brpc_pkg::TC_I16, brpc_pkg::TC_I32,
    brpc_pkg::TC_U64, brpc_pkg::TC_I64, brpc_pkg::TC_STRING, brpc_pkg::TC_UTF8,
    brpc_pkg::TC_UTF16, brpc_pkg::TC_STRUCT, brpc_pkg::TC_MAP, brpc_pkg::TC_SET,
    brpc_pkg::TC_LIST};

  function automatic void put32(logic [31:0] v);
    for (int i = 3; i >= 0; i--) wire_q.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_rand(int n);
    for (int i = 0; i < n; i++) wire_q.push_back(8'($urandom));
  endfunction

  // mostly known codes; now and then a code that the walker refuses
  function automatic logic [7:0] pick_type(int lvl_now, bit elem);
    logic [7:0] c;
    if ($urandom_range(0, 59) == 0) return 8'($urandom_range(18, 255));
    if ($urandom_range(0, 79) == 0) return $urandom_range(0, 1) ? 8'd5 : 8'd7;
    if (elem && $urandom_range(0, 9) == 0) return 8'(brpc_pkg::TC_STOP);
    do c = 8'(FIELD_TYPES[$urandom_range(0, 14)]);
    while (lvl_now >= 3 && c >= 8'd12 && c <= 8'd15);
    return c;
  endfunction

  function automatic void put_value(logic [7:0] t, int lvl_now);
    int n;
    logic [7:0] kt, vt;
    case (t)
      8'd2, 8'd3: put_rand(1);
      8'd6: put_rand(2);
      8'd8: put_rand(4);
      8'd4, 8'd9, 8'd10: put_rand(8);
      8'd11, 8'd16, 8'd17: begin
        n = $urandom_range(0, 4);
        put32(n);
        put_rand(n);
      end
      8'd12: put_struct(lvl_now + 1);
      8'd13: begin
        kt = pick_type(lvl_now + 1, 1'b1);
        vt = pick_type(lvl_now + 1, 1'b1);
        n = $urandom_range(0, 3);
        wire_q.push_back(kt); wire_q.push_back(vt);
        put32(n);
        for (int i = 0; i < n; i++) begin
          put_value(kt, lvl_now + 1);
          put_value(vt, lvl_now + 1);
        end
      end
      8'd14, 8'd15: begin
        kt = pick_type(lvl_now + 1, 1'b1);
        n = $urandom_range(0, 3);
        wire_q.push_back(kt);
        put32(n);
        for (int i = 0; i < n; i++) put_value(kt, lvl_now + 1);
      end
      default: ;   // zero-size or refused codes carry nothing
    endcase
  endfunction

  function automatic void put_struct(int lvl_now);
    int nf;
    logic [7:0] t;
    nf = $urandom_range(0, 3);
    for (int i = 0; i < nf; i++) begin
      t = pick_type(lvl_now, 1'b0);
      wire_q.push_back(t);
      put_rand(2);
      put_value(t, lvl_now);
    end
    wire_q.push_back(8'h00);
  endfunction

  function automatic void put_header();
    int k, n;
    k = $urandom_range(0, 9);
    if (k < 7) begin
      // versioned; a few with a broken version half
      wire_q.push_back(8'h80);
      wire_q.push_back(k == 0 ? 8'($urandom) : 8'h01);
      wire_q.push_back(8'($urandom));
      wire_q.push_back(8'($urandom));
      case ($urandom_range(0, 19))
        0: put32(32'hffff_fffc);             // name length wraps to no skip
        1: begin put32(32'hffff_ffff); put_rand(3); end
        default: begin
          n = $urandom_range(0, 5);
          put32(n);
          put_rand(n + 4);
        end
      endcase
    end else begin
      // unversioned: name, type byte, sequence id
      n = $urandom_range(0, 5);
      put32(n);
      put_rand(n + 5);
    end
  endfunction

  // builds one message and queues it; a few are cut short or are noise
  task automatic queue_message();
    int k, cut;
    wire_q.delete();
    k = $urandom_range(0, 19);
    if (k == 0) begin
      put_rand($urandom_range(1, 12));
    end else if (k == 1) begin
      // nesting chain around the stack limit
      put_header();
      cut = $urandom_range(DEPTH - 2, DEPTH);
      for (int i = 0; i < cut; i++) begin
        wire_q.push_back(8'(brpc_pkg::TC_STRUCT));
        put_rand(2);
      end
      for (int i = 0; i <= cut; i++) wire_q.push_back(8'h00);
    end else begin
      put_header();
      put_struct(1);
      if (k == 2) wire_q = wire_q[0:$urandom_range(0, wire_q.size() - 1)];
      if (k == 3) put_rand($urandom_range(1, 3));   // trailing bytes
    end
    for (int i = 0; i < wire_q.size(); i++)
      byte_q.push_back('{wire_q[i], (i == 0) ? ($urandom_range(0, 15) != 0) : 1'b0,
                         1'b0, '0});
  endtask

  // ---------------------------------------------------------------- directed table
  typedef struct packed {
    logic [7:0] b;
    logic       first;
    logic       typed;
    logic [2:0] role;
    logic [4:0] depth;
    logic [7:0] mt;
    logic       last;
    logic [2:0] err;
  } dir_row_t;

  localparam int NDIR = 31;
  localparam dir_row_t DIR_TAB[NDIR] = '{
    // versioned exception header, empty name, empty body
    '{8'h80, 1'b1, 1'b1, brpc_pkg::ROLE_HEADER,  5'd0, 8'd0, 1'b0, brpc_pkg::ERR_NONE},
    '{8'h01, 1'b0, 1'b1, brpc_pkg::ROLE_HEADER,  5'd0, 8'd0, 1'b0, brpc_pkg::ERR_NONE},
    '{8'h00, 1'b0, 1'b1, brpc_pkg::ROLE_HEADER,  5'd0, 8'd0, 1'b0, brpc_pkg::ERR_NONE},
    '{8'h03, 1'b0, 1'b1, brpc_pkg::ROLE_HEADER,  5'd0, 8'd3, 1'b0, brpc_pkg::ERR_NONE},
    '{8'h00, 1'b0, 1'b1, brpc_pkg::ROLE_HEADER,  5'd0, 8'd3, 1'b0, brpc_pkg::ERR_NONE},
    '{8'h00, 1'b0, 1'b1, brpc_pkg::ROLE_HEADER,  5'd0, 8'd3, 1'b0, brpc_pkg::ERR_NONE},
    '{8'h00, 1'b0, 1'b1, brpc_pkg::ROLE_HEADER,  5'd0, 8'd3, 1'b0, brpc_pkg::ERR_NONE},
    '{8'h00, 1'b0, 1'b1, brpc_pkg::ROLE_HEADER,  5'd0, 8'd3, 1'b0, brpc_pkg::ERR_NONE},
    '{8'hff, 1'b0, 1'b1, brpc_pkg::ROLE_HEADER,  5'd0, 8'd3, 1'b0, brpc_pkg::ERR_NONE},
    '{8'h55, 1'b0, 1'b1, brpc_pkg::ROLE_HEADER,  5'd0, 8'd3, 1'b0, brpc_pkg::ERR_NONE},
    '{8'haa, 1'b0, 1'b1, brpc_pkg::ROLE_HEADER,  5'd0, 8'd3, 1'b0, brpc_pkg::ERR_NONE},
    '{8'h00, 1'b0, 1'b1, brpc_pkg::ROLE_HEADER,  5'd1, 8'd3, 1'b0, brpc_pkg::ERR_NONE},
    '{8'h00, 1'b0, 1'b1, brpc_pkg::ROLE_STOP,    5'd0, 8'd3, 1'b1, brpc_pkg::ERR_NONE},
    '{8'hab, 1'b0, 1'b1, brpc_pkg::ROLE_IGNORED, 5'd0, 8'd3, 1'b0, brpc_pkg::ERR_NONE},
    // bad version
    '{8'h80, 1'b1, 1'b1, brpc_pkg::ROLE_HEADER,  5'd0, 8'd0, 1'b0, brpc_pkg::ERR_NONE},
    '{8'h02, 1'b0, 1'b1, brpc_pkg::ROLE_HEADER,  5'd0, 8'd0, 1'b0, brpc_pkg::ERR_NONE},
    '{8'h00, 1'b0, 1'b1, brpc_pkg::ROLE_HEADER,  5'd0, 8'd0, 1'b0, brpc_pkg::ERR_NONE},
    '{8'hff, 1'b0, 1'b1, brpc_pkg::ROLE_HEADER,  5'd0, 8'd0, 1'b0, brpc_pkg::ERR_VERSION},
    '{8'hff, 1'b0, 1'b1, brpc_pkg::ROLE_IGNORED, 5'd0, 8'd0, 1'b0, brpc_pkg::ERR_VERSION},
    // unversioned, empty name, then a field of a refused type
    '{8'h00, 1'b1, 1'b0, '0, '0, '0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0},
    '{8'h07, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0},
    '{8'h02, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0}
  };

  // ---------------------------------------------------------------- sender
  // Holds one offered byte until the core takes it; each taken byte is walked
  // by the model right away so predictions stay in order.
  byte_item_t offered;
  bit         have_byte = 1'b0;

  always @(posedge clk) begin : send_proc
    brpc_pkg::out_beat_t p;
    if (rst_n) begin
      if (push && !full) begin
        p = walk_byte(offered.b, offered.first);
        beat_q.push_back(offered.typed ? offered.want : p);
        have_byte = 1'b0;
      end
      if (!have_byte && byte_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        offered = byte_q.pop_front();
        have_byte = 1'b1;
      end
      push <= have_byte;
      in_data_byte <= offered.b;
      in_first <= offered.first;
    end
  end

  // ---------------------------------------------------------------- receiver
  int hold_cnt = 0;

  always @(posedge clk) begin : recv_proc
    brpc_pkg::out_beat_t w;
    if (rst_n) begin
      if (pop && !empty) begin
        if (beat_q.size() == 0) begin
          $error("beat with nothing expected: role %0d", out_role);
          errs++;
        end else begin
          w = beat_q.pop_front();
          if (out_role !== w.role) begin
            $error("role exp %0d got %0d", w.role, out_role); errs++;
          end
          if (out_depth !== w.depth) begin
            $error("depth exp %0d got %0d", w.depth, out_depth); errs++;
          end
          if (out_message_type !== w.message_type) begin
            $error("message_type exp %0d got %0d", w.message_type, out_message_type);
            errs++;
          end
          if (out_last !== w.last) begin
            $error("last exp %0d got %0d", w.last, out_last); errs++;
          end
          if (out_error !== w.error) begin
            $error("error exp %0d got %0d", w.error, out_error); errs++;
          end
        end
      end
      // long hold-off: lets the core fill up and push back on the sender
      if (hold_req) begin
        hold_cnt = 400;
        hold_req = 1'b0;
      end
      if (hold_cnt > 0) hold_cnt--;
      pop <= (hold_cnt == 0) && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------- sequencing
  task automatic drain();
    while (byte_q.size() > 0 || have_byte || beat_q.size() > 0) @(posedge clk);
    // settle margin before the next register write
    repeat (40) @(posedge clk);
  endtask

  task automatic write_strict(logic v);
    cfg_wr_en <= 1'b1;
    cfg_strict <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    strict_mode = v;
  endtask

  initial begin : main_proc
    int sent;
    walker_clear();
    strict_mode = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_strict(1'b0);

    foreach (DIR_TAB[i])
      byte_q.push_back('{DIR_TAB[i].b, DIR_TAB[i].first, DIR_TAB[i].typed,
                         '{DIR_TAB[i].role, DIR_TAB[i].depth, DIR_TAB[i].mt,
                           DIR_TAB[i].last, DIR_TAB[i].err}});
    drain();

    // four phases of about 400 bytes, each with its own idle pattern
    for (int ph = 0; ph < 4; ph++) begin
      write_strict(ph[0]);
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      if (ph == 0) hold_req = 1'b1;
      sent = 0;
      while (sent < 400) begin
        queue_message();
        sent = sent + wire_q.size();
      end
      drain();
    end

    if (errs == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
